// ===== hdl/af2f_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// af2f_pkg: shared types and constants
// Format codes, status codes, header positions and the result record.
// ----------------------------------------------------------------------------
package af2f_pkg;

   typedef enum logic [2:0] {
      FMT_INT16   = 3'd0,
      FMT_INT24   = 3'd1,
      FMT_INT32   = 3'd2,
      FMT_FLOAT32 = 3'd3,
      FMT_UNKNOWN = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SHORT    = 2'd1,
      STAT_UNSUPP   = 2'd2,
      STAT_NOSAMPLE = 2'd3
   } status_type;

   localparam int HeaderBytes = 32;
   localparam logic [5:0] FmtPos   = 6'd11;
   localparam logic [5:0] CountPos = 6'd23;

   // Result of the conversion stage towards the output register.
   typedef struct packed {
      logic [31:0] bits;
      logic        valid;
      logic        done;
      logic [1:0]  status;
   } result_type;

endpackage

// ===== hdl/af2f_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// af2f_conv: integer sample to float32 converter
// Combinational conversion of a 16, 24 or 32 bit two's-complement sample,
// scaled by 2^-(width-1), with round to nearest even; float32 passes through.
// ----------------------------------------------------------------------------
module af2f_conv
   import af2f_pkg::*;
(
   input  fmt_type     fmt,
   input  logic [31:0] raw,
   output logic [31:0] bits
);

   logic [31:0] sext;
   logic        neg;
   logic [31:0] mag;
   logic [4:0]  lead;
   logic [31:0] norm;
   logic [24:0] mant;
   logic        rnd;
   logic [7:0]  expo;
   logic [7:0]  frac;
   logic        found;

   always_comb begin
      // Sign-extend according to the sample width.
      case (fmt)
         FMT_INT16: sext = {{16{raw[15]}}, raw[15:0]};
         FMT_INT24: sext = {{8{raw[23]}}, raw[23:0]};
         default:   sext = raw;
      endcase
      case (fmt)
         FMT_INT16: frac = 8'd15;
         FMT_INT24: frac = 8'd23;
         default:   frac = 8'd31;
      endcase
      neg = sext[31];
      mag = neg ? (~sext + 32'd1) : sext;

      // Leading one search (priority encoder).
      lead  = 5'd0;
      found = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (!found && mag[i]) begin
            lead  = 5'(i);
            found = 1'b1;
         end
      end

      // Normalise so the leading one sits at bit 31, then round to 24 bits.
      norm = mag << (5'd31 - lead);
      rnd  = norm[7] && (norm[8] || (norm[6:0] != 7'd0));
      mant = {1'b0, norm[31:8]} + {24'd0, rnd};
      expo = 8'd127 + {3'd0, lead} - frac + {7'd0, mant[24]};

      if (fmt == FMT_FLOAT32) begin
         bits = raw;
      end else if (!found) begin
         bits = 32'd0;
      end else begin
         bits = {neg, expo, mant[24] ? mant[23:1] : mant[22:0]};
      end
   end

endmodule

// ===== hdl/af2f_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// af2f_parse: frame header parser and sample assembler
// Tracks the header, keeps format and count, builds payload samples and
// produces one combinational result per sample within the count or frame end.
// ----------------------------------------------------------------------------
module af2f_parse
   import af2f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  byte_in,
   input  logic        end_in,
   output logic        emit,
   output result_type  res
);

   logic [5:0]  hpos_ff, hpos_in;
   logic [31:0] hword_ff, hword_in;
   fmt_type     fmt_ff, fmt_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] emitted_ff, emitted_in;
   logic [31:0] asm_ff, asm_in;
   logic [2:0]  gath_ff, gath_in;

   logic        in_header;
   logic        supported;
   logic [2:0]  width;
   logic [31:0] asm_next;
   logic [2:0]  gath_next;
   logic [31:0] conv_bits;

   assign in_header = hpos_ff < 6'(HeaderBytes);
   assign supported = (fmt_ff != FMT_UNKNOWN) && (count_ff != 32'd0) && !count_ff[31];

   always_comb begin
      case (fmt_ff)
         FMT_INT16: width = 3'd2;
         FMT_INT24: width = 3'd3;
         default:   width = 3'd4;
      endcase
   end

   assign asm_next  = asm_ff | ({24'd0, byte_in} << {gath_ff[1:0], 3'b000});
   assign gath_next = gath_ff + 3'd1;

   af2f_conv u_conv (
      .fmt  (fmt_ff),
      .raw  (asm_next),
      .bits (conv_bits)
   );

   // Next-state and result logic for one request.
   always_comb begin
      hpos_in    = hpos_ff;
      hword_in   = hword_ff;
      fmt_in     = fmt_ff;
      count_in   = count_ff;
      emitted_in = emitted_ff;
      asm_in     = asm_ff;
      gath_in    = gath_ff;
      res        = '0;

      if (in_header) begin
         hword_in = {byte_in, hword_ff[31:8]};
         if (hpos_ff == FmtPos) begin
            fmt_in = (hword_in <= 32'd3) ? fmt_type'(hword_in[2:0]) : FMT_UNKNOWN;
         end
         if (hpos_ff == CountPos) begin
            count_in = hword_in;
         end
         hpos_in = hpos_ff + 6'd1;
      end else if (supported) begin
         asm_in  = asm_next;
         gath_in = gath_next;
         if (gath_next >= width) begin
            if (emitted_ff < count_ff) begin
               res.bits   = conv_bits;
               res.valid  = 1'b1;
               emitted_in = emitted_ff + 32'd1;
            end
            asm_in  = 32'd0;
            gath_in = 3'd0;
         end
      end

      // The status sees the header position after this request's byte.
      if (end_in) begin
         res.done = 1'b1;
         if (hpos_in < 6'(HeaderBytes)) begin
            res.status = STAT_SHORT;
         end else if (!supported) begin
            res.status = STAT_UNSUPP;
         end else if (emitted_in == 32'd0) begin
            res.status = STAT_NOSAMPLE;
         end else begin
            res.status = STAT_OK;
         end
         hpos_in    = '0;
         hword_in   = '0;
         fmt_in     = FMT_INT16;
         count_in   = '0;
         emitted_in = '0;
         asm_in     = '0;
         gath_in    = '0;
      end
   end

   assign emit = take && (res.valid || res.done);

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hpos_ff    <= '0;
         hword_ff   <= '0;
         fmt_ff     <= FMT_INT16;
         count_ff   <= '0;
         emitted_ff <= '0;
         asm_ff     <= '0;
         gath_ff    <= '0;
      end else if (take) begin
         hpos_ff    <= hpos_in;
         hword_ff   <= hword_in;
         fmt_ff     <= fmt_in;
         count_ff   <= count_in;
         emitted_ff <= emitted_in;
         asm_ff     <= asm_in;
         gath_ff    <= gath_in;
      end
   end

endmodule

// ===== hdl/audio_frame_to_float32_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_frame_to_float32_top: audio frame to float32 sample converter
// Usage:
//  - The req_ channel carries one frame byte per request, with frame_end on
//    the last byte. The first 32 bytes are the header (format, count).
//  - The rsp_ channel carries one result per sample within the count, and
//    one on the frame's last byte, with frame_done and frame_status.
//  - The request's state update and float conversion are combinational,
//    and the result is registered in the cycle after the handshake.
//  - One byte is taken per cycle while req_stall is low; the single result
//    register is refilled in the same cycle it is taken.
//  - While rsp_stall holds a waiting result, req_stall is raised and every
//    request waits, whether or not it would give a result; nothing is lost.
//  - Reset (synchronous) clears the header position, counters and the
//    result valid flag; the block then expects a new frame header.
// ----------------------------------------------------------------------------
module audio_frame_to_float32_top
   import af2f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_sample_bits,
   output logic        rsp_sample_valid,
   output logic        rsp_frame_done,
   output logic [1:0]  rsp_frame_status
);

   logic       take;
   logic       emit;
   result_type res;
   result_type out_ff;
   logic       valid_ff;

   // Stall input only while a result waits and the receiver stalls.
   assign req_stall = valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   af2f_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .byte_in (req_byte_value),
      .end_in  (req_frame_end),
      .emit    (emit),
      .res     (res)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sample_bits  = out_ff.bits;
   assign rsp_sample_valid = out_ff.valid;
   assign rsp_frame_done   = out_ff.done;
   assign rsp_frame_status = out_ff.status;

endmodule

// ===== hdl/af2f_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// af2f_checker: port-level checks
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module af2f_checker
   import af2f_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_sample_bits,
   input logic        rsp_sample_valid,
   input logic        rsp_frame_done,
   input logic [1:0]  rsp_frame_status
);

   // A stalled result stays valid and holds its sample bits.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_bits))
      else $error("stalled result changed");

   // Every result carries a sample or a frame end.
   a_content: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_valid || rsp_frame_done)
      else $error("empty result");

   // Status is only non-zero on a frame end result.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_frame_status == STAT_OK)
      else $error("status outside frame end");

   // Input stalls only when a result is waiting under stall.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("needless request stall");

endmodule

bind audio_frame_to_float32_top af2f_checker u_af2f_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample_bits  (rsp_sample_bits),
   .rsp_sample_valid (rsp_sample_valid),
   .rsp_frame_done   (rsp_frame_done),
   .rsp_frame_status (rsp_frame_status)
);
